// ===== hdl/hed_pkg.sv =====
// Shared types, constants and lookup functions of the HTML entity decoder.
`timescale 1ns / 1ps
`default_nettype none

package hed_pkg;

   localparam int HED_MAX_ENTITY_LEN = 16;
   localparam int NAME_COUNT = 6;

   localparam logic [7:0] CHAR_AMP   = 8'h26;
   localparam logic [7:0] CHAR_HASH  = 8'h23;
   localparam logic [7:0] CHAR_SEMI  = 8'h3B;
   localparam logic [7:0] CHAR_X_LO  = 8'h78;
   localparam logic [7:0] CHAR_X_UP  = 8'h58;
   localparam logic [7:0] CHAR_LT    = 8'h3C;
   localparam logic [7:0] CHAR_GT    = 8'h3E;
   localparam logic [7:0] CHAR_QUOT  = 8'h22;
   localparam logic [7:0] CHAR_APOS  = 8'h27;
   localparam logic [7:0] CHAR_SPACE = 8'h20;

   localparam logic [20:0] CODE_LIMIT     = 21'h110000;
   localparam logic [20:0] SURROGATE_LOW  = 21'h00D800;
   localparam logic [20:0] SURROGATE_HIGH = 21'h00DFFF;

   // Entity names without the leading ampersand, padded with zero bytes.
   localparam logic [0:NAME_COUNT-1][0:4][7:0] NAME_TEXT = {
      {"a", "m", "p", ";", 8'h00},
      {"l", "t", ";", 8'h00, 8'h00},
      {"g", "t", ";", 8'h00, 8'h00},
      {"q", "u", "o", "t", ";"},
      {"a", "p", "o", "s", ";"},
      {"n", "b", "s", "p", ";"}
   };

   typedef enum logic [1:0] {
      MODE_IDLE,
      MODE_NAME,
      MODE_NUM
   } mode_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_FLUSH1,
      S_TAIL,
      S_FLUSH2
   } ctrl_state_type;

   typedef enum logic [1:0] {
      SRC_DIRECT,
      SRC_BUFFER,
      SRC_TAIL
   } src_type;

   typedef struct packed {
      logic       accept;
      logic       load;
      src_type    sel;
      logic [1:0] tail_idx;
      logic       step;
      logic       rewind;
   } cmd_type;

   typedef struct packed {
      logic [2:0] tail_cnt;
      logic       last;
   } plan_type;

   typedef struct packed {
      logic [2:0]        count;
      logic [0:3][7:0]   bytes;
   } utf8_type;

   function automatic logic [2:0] name_len(input int idx);
      logic [2:0] len;
      case (idx)
         0: len = 3'd4;
         1: len = 3'd3;
         2: len = 3'd3;
         default: len = 3'd5;
      endcase
      return len;
   endfunction

   function automatic logic [7:0] name_value(input int idx);
      logic [7:0] value;
      case (idx)
         0: value = CHAR_AMP;
         1: value = CHAR_LT;
         2: value = CHAR_GT;
         3: value = CHAR_QUOT;
         4: value = CHAR_APOS;
         default: value = CHAR_SPACE;
      endcase
      return value;
   endfunction

   function automatic logic [7:0] name_char(input int idx, input logic [2:0] pos);
      logic [7:0] ch;
      ch = 8'h00;
      if (pos < 3'd5) begin
         ch = NAME_TEXT[idx][pos];
      end
      return ch;
   endfunction

   function automatic utf8_type utf8_encode(input logic [20:0] cp);
      utf8_type r;
      r.bytes = '0;
      if (cp < 21'h80) begin
         r.count = 3'd1;
         r.bytes[0] = {1'b0, cp[6:0]};
      end else if (cp < 21'h800) begin
         r.count = 3'd2;
         r.bytes[0] = {3'b110, cp[10:6]};
         r.bytes[1] = {2'b10, cp[5:0]};
      end else if (cp < 21'h10000) begin
         r.count = 3'd3;
         r.bytes[0] = {4'b1110, cp[15:12]};
         r.bytes[1] = {2'b10, cp[11:6]};
         r.bytes[2] = {2'b10, cp[5:0]};
      end else begin
         r.count = 3'd4;
         r.bytes[0] = {5'b11110, cp[20:18]};
         r.bytes[1] = {2'b10, cp[17:12]};
         r.bytes[2] = {2'b10, cp[11:6]};
         r.bytes[3] = {2'b10, cp[5:0]};
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/hed_channels.sv =====
// Valid/ready channel interfaces for the decoder's input text and decoded output.
`timescale 1ns / 1ps
`default_nettype none

interface hed_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       is_last;

   modport source (output valid, output text_byte, output is_last, input ready);
   modport sink (input valid, input text_byte, input is_last, output ready);
endinterface

interface hed_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       run_end;
   logic       text_end;

   modport source (output valid, output out_byte, output run_end, output text_end,
                   input ready);
   modport sink (input valid, input out_byte, input run_end, input text_end,
                 output ready);
endinterface

`default_nettype wire

// ===== hdl/hed_datapath.sv =====
// Datapath: reference buffer, entity and number decoding, tail bytes and output byte.
`timescale 1ns / 1ps
`default_nettype none

module hed_datapath import hed_pkg::*; #(
   parameter int MAX_ENTITY_LEN = HED_MAX_ENTITY_LEN,
   localparam int CNT_W = $clog2(MAX_ENTITY_LEN + 1),
   localparam int IDX_W = $clog2(MAX_ENTITY_LEN)
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic [7:0]       text_byte,
   input  wire logic             is_last,
   input  wire cmd_type          cmd,
   output plan_type              plan,
   output logic [CNT_W-1:0]      f1_cnt,
   output logic [CNT_W-1:0]      f2_cnt,
   output logic [7:0]            out_byte
);

   logic [CNT_W-1:0]     pend_cnt_ff, pend_cnt_in;
   mode_type             mode_ff, mode_in;
   logic [20:0]          code_ff, code_in;
   logic                 big_ff, big_in;
   logic                 hex_ff, hex_in;
   logic [NAME_COUNT-1:0] mask_ff, mask_in;
   logic [0:3][7:0]      tail_ff, tail_bytes;
   logic [7:0]           out_byte_ff, out_byte_in;
   logic [IDX_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [7:0]           rd_data_ff;
   logic [7:0]           pend_mem [MAX_ENTITY_LEN];

   logic [CNT_W-1:0]     k;
   logic                 full;
   logic [NAME_COUNT-1:0] hit, complete;
   logic [7:0]           name_out;
   mode_type             eff_mode;
   logic [3:0]           digit;
   logic                 digit_ok;
   logic [24:0]          grown;
   logic                 code_ok;
   utf8_type             utf8;
   logic                 store, amp_wr, fail, fresh, go_idle;
   logic [2:0]           tail_cnt;
   logic                 wr_en;
   logic [IDX_W-1:0]     wr_addr;
   logic [7:0]           wr_data;

   assign k    = pend_cnt_ff - CNT_W'(1);
   assign full = pend_cnt_ff >= CNT_W'(MAX_ENTITY_LEN);
   assign eff_mode = (pend_cnt_ff == '0) ? MODE_IDLE : mode_ff;

   // Candidate names are narrowed one byte at a time, so the buffer is never reread.
   always_comb begin
      name_out = 8'h00;
      for (int i = 0; i < NAME_COUNT; i++) begin
         hit[i] = mask_ff[i] && (k < CNT_W'(name_len(i))) &&
                  (name_char(i, k[2:0]) == text_byte);
         complete[i] = hit[i] && ((k + CNT_W'(1)) == CNT_W'(name_len(i)));
         if (complete[i]) begin
            name_out = name_value(i);
         end
      end
   end

   always_comb begin
      digit_ok = 1'b0;
      digit    = 4'd0;
      if (text_byte >= "0" && text_byte <= "9") begin
         digit_ok = 1'b1;
         digit    = 4'(text_byte - "0");
      end else if (hex_ff && text_byte >= "a" && text_byte <= "f") begin
         digit_ok = 1'b1;
         digit    = 4'(text_byte - 8'h57);
      end else if (hex_ff && text_byte >= "A" && text_byte <= "F") begin
         digit_ok = 1'b1;
         digit    = 4'(text_byte - 8'h37);
      end
   end

   assign grown = hex_ff ? ({code_ff, 4'b0000} + 25'(digit))
                         : ({1'b0, code_ff, 3'b000} + {3'b000, code_ff, 1'b0} + 25'(digit));
   assign code_ok = !big_ff && (code_ff != '0) && (code_ff < CODE_LIMIT) &&
                    !(code_ff >= SURROGATE_LOW && code_ff <= SURROGATE_HIGH);
   assign utf8 = utf8_encode(code_ff);

   always_comb begin
      pend_cnt_in = pend_cnt_ff;
      mode_in     = mode_ff;
      code_in     = code_ff;
      big_in      = big_ff;
      hex_in      = hex_ff;
      mask_in     = mask_ff;
      tail_bytes  = '0;
      tail_cnt    = 3'd0;
      f1_cnt      = '0;
      store       = 1'b0;
      amp_wr      = 1'b0;
      fail        = 1'b0;
      fresh       = 1'b0;
      go_idle     = 1'b0;
      case (eff_mode)
         MODE_NAME: begin
            if (k == '0 && text_byte == CHAR_HASH) begin
               if (full) begin
                  fail = 1'b1;
               end else begin
                  store   = 1'b1;
                  mode_in = MODE_NUM;
                  hex_in  = 1'b0;
                  code_in = '0;
                  big_in  = 1'b0;
               end
            end else if (|complete) begin
               tail_bytes[0] = name_out;
               tail_cnt      = 3'd1;
               go_idle       = 1'b1;
            end else if (|hit && !full) begin
               store   = 1'b1;
               mask_in = hit;
            end else begin
               fail = 1'b1;
            end
         end
         MODE_NUM: begin
            if (text_byte == CHAR_SEMI) begin
               go_idle = 1'b1;
               if (code_ok) begin
                  tail_bytes = utf8.bytes;
                  tail_cnt   = utf8.count;
               end else begin
                  // A rejected number goes out literally, followed by the semicolon.
                  f1_cnt        = pend_cnt_ff;
                  tail_bytes[0] = CHAR_SEMI;
                  tail_cnt      = 3'd1;
               end
            end else if (pend_cnt_ff == CNT_W'(2) && !hex_ff &&
                         (text_byte == CHAR_X_LO || text_byte == CHAR_X_UP)) begin
               if (full) begin
                  fail = 1'b1;
               end else begin
                  store  = 1'b1;
                  hex_in = 1'b1;
               end
            end else if (!digit_ok || full) begin
               fail = 1'b1;
            end else begin
               store = 1'b1;
               if (!big_ff) begin
                  if (grown > 25'h10FFFF) begin
                     big_in = 1'b1;
                  end else begin
                     code_in = grown[20:0];
                  end
               end
            end
         end
         default: begin
            fresh = 1'b1;
         end
      endcase

      if (fail) begin
         f1_cnt = pend_cnt_ff;
         fresh  = 1'b1;
      end
      if (go_idle || fresh) begin
         pend_cnt_in = '0;
         mode_in     = MODE_IDLE;
         code_in     = '0;
         big_in      = 1'b0;
         hex_in      = 1'b0;
      end
      if (fresh) begin
         if (text_byte == CHAR_AMP) begin
            amp_wr      = 1'b1;
            pend_cnt_in = CNT_W'(1);
            mode_in     = MODE_NAME;
            mask_in     = '1;
         end else begin
            tail_bytes[0] = text_byte;
            tail_cnt      = 3'd1;
         end
      end
      if (store) begin
         pend_cnt_in = pend_cnt_ff + CNT_W'(1);
      end

      // The final byte of the text flushes whatever is still buffered.
      f2_cnt = is_last ? pend_cnt_in : '0;
      if (is_last) begin
         pend_cnt_in = '0;
         mode_in     = MODE_IDLE;
         code_in     = '0;
         big_in      = 1'b0;
         hex_in      = 1'b0;
      end
   end

   assign plan.tail_cnt = tail_cnt;
   assign plan.last     = is_last;

   assign wr_en   = cmd.accept && (store || amp_wr);
   assign wr_addr = store ? pend_cnt_ff[IDX_W-1:0] : '0;
   assign wr_data = store ? text_byte : CHAR_AMP;

   always_comb begin
      rd_ptr_in = rd_ptr_ff;
      if (cmd.rewind) begin
         rd_ptr_in = '0;
      end else if (cmd.step) begin
         rd_ptr_in = rd_ptr_ff + IDX_W'(1);
      end
   end

   // Write-first buffer: the read register always holds the entry at rd_ptr_ff.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         pend_mem[wr_addr] <= wr_data;
      end
      if (wr_en && wr_addr == rd_ptr_in) begin
         rd_data_ff <= wr_data;
      end else begin
         rd_data_ff <= pend_mem[rd_ptr_in];
      end
   end

   always_comb begin
      case (cmd.sel)
         SRC_DIRECT: out_byte_in = tail_bytes[0];
         SRC_BUFFER: out_byte_in = rd_data_ff;
         SRC_TAIL:   out_byte_in = tail_ff[cmd.tail_idx];
         default:    out_byte_in = rd_data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_cnt_ff <= '0;
         mode_ff     <= MODE_IDLE;
         code_ff     <= '0;
         big_ff      <= 1'b0;
         hex_ff      <= 1'b0;
         rd_ptr_ff   <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         if (cmd.accept) begin
            pend_cnt_ff <= pend_cnt_in;
            mode_ff     <= mode_in;
            code_ff     <= code_in;
            big_ff      <= big_in;
            hex_ff      <= hex_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         mask_ff <= mask_in;
         tail_ff <= tail_bytes;
      end
      if (cmd.load) begin
         out_byte_ff <= out_byte_in;
      end
   end

   assign out_byte = out_byte_ff;

endmodule

`default_nettype wire

// ===== hdl/hed_ctrl.sv =====
// Controller: accepts text bytes and sequences flushed, decoded and trailing result bytes.
`timescale 1ns / 1ps
`default_nettype none

module hed_ctrl import hed_pkg::*; #(
   parameter int MAX_ENTITY_LEN = HED_MAX_ENTITY_LEN,
   localparam int CNT_W = $clog2(MAX_ENTITY_LEN + 1)
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire logic             rsp_ready,
   output logic                  rsp_valid,
   output logic                  run_end,
   output logic                  text_end,
   input  wire plan_type         plan,
   input  wire logic [CNT_W-1:0] f1_cnt,
   input  wire logic [CNT_W-1:0] f2_cnt,
   output cmd_type               cmd
);

   ctrl_state_type   state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0] f2_ff, f2_in;
   logic [2:0]       tcnt_ff, tcnt_in;
   logic [1:0]       tidx_ff, tidx_in;
   logic             last_ff, last_in;
   logic             valid_ff, valid_in;
   logic             run_end_ff, run_end_in;
   logic             text_end_ff, text_end_in;
   logic             out_free;
   logic             accept;
   logic             fin;

   assign out_free  = !valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) && out_free;
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      f2_in       = f2_ff;
      tcnt_in     = tcnt_ff;
      tidx_in     = tidx_ff;
      last_in     = last_ff;
      valid_in    = valid_ff && !rsp_ready;
      run_end_in  = run_end_ff;
      text_end_in = text_end_ff;
      fin         = 1'b0;
      cmd         = '{accept: 1'b0, load: 1'b0, sel: SRC_DIRECT, tail_idx: tidx_ff,
                      step: 1'b0, rewind: 1'b0};
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.accept = 1'b1;
               cmd.rewind = 1'b1;
               tcnt_in    = plan.tail_cnt;
               f2_in      = f2_cnt;
               last_in    = plan.last;
               if (f1_cnt != '0) begin
                  cnt_in   = f1_cnt;
                  state_in = S_FLUSH1;
               end else if (plan.tail_cnt != 3'd0) begin
                  // The first decoded or passed-through byte goes straight to the output register.
                  fin         = (plan.tail_cnt == 3'd1) && (f2_cnt == '0);
                  cmd.load    = 1'b1;
                  cmd.sel     = SRC_DIRECT;
                  valid_in    = 1'b1;
                  run_end_in  = fin;
                  text_end_in = fin && plan.last;
                  if (plan.tail_cnt != 3'd1) begin
                     tidx_in  = 2'd1;
                     state_in = S_TAIL;
                  end else if (f2_cnt != '0) begin
                     cnt_in   = f2_cnt;
                     state_in = S_FLUSH2;
                  end
               end else if (f2_cnt != '0) begin
                  cnt_in   = f2_cnt;
                  state_in = S_FLUSH2;
               end
            end
         end
         S_FLUSH1: begin
            if (out_free) begin
               cmd.load = 1'b1;
               cmd.sel  = SRC_BUFFER;
               cnt_in   = cnt_ff - CNT_W'(1);
               if (cnt_ff == CNT_W'(1)) begin
                  fin        = (tcnt_ff == 3'd0) && (f2_ff == '0);
                  cmd.rewind = 1'b1;
                  if (tcnt_ff != 3'd0) begin
                     tidx_in  = 2'd0;
                     state_in = S_TAIL;
                  end else if (f2_ff != '0) begin
                     cnt_in   = f2_ff;
                     state_in = S_FLUSH2;
                  end else begin
                     state_in = S_IDLE;
                  end
               end else begin
                  cmd.step = 1'b1;
               end
               valid_in    = 1'b1;
               run_end_in  = fin;
               text_end_in = fin && last_ff;
            end
         end
         S_TAIL: begin
            if (out_free) begin
               cmd.load = 1'b1;
               cmd.sel  = SRC_TAIL;
               if ((3'(tidx_ff) + 3'd1) == tcnt_ff) begin
                  fin = (f2_ff == '0);
                  if (f2_ff != '0) begin
                     cnt_in   = f2_ff;
                     state_in = S_FLUSH2;
                  end else begin
                     state_in = S_IDLE;
                  end
               end else begin
                  tidx_in = tidx_ff + 2'd1;
               end
               valid_in    = 1'b1;
               run_end_in  = fin;
               text_end_in = fin && last_ff;
            end
         end
         S_FLUSH2: begin
            if (out_free) begin
               cmd.load = 1'b1;
               cmd.sel  = SRC_BUFFER;
               cnt_in   = cnt_ff - CNT_W'(1);
               if (cnt_ff == CNT_W'(1)) begin
                  fin        = 1'b1;
                  cmd.rewind = 1'b1;
                  state_in   = S_IDLE;
               end else begin
                  cmd.step = 1'b1;
               end
               valid_in    = 1'b1;
               run_end_in  = fin;
               text_end_in = fin && last_ff;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
         cnt_ff   <= '0;
         f2_ff    <= '0;
         tcnt_ff  <= 3'd0;
         tidx_ff  <= 2'd0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         cnt_ff   <= cnt_in;
         f2_ff    <= f2_in;
         tcnt_ff  <= tcnt_in;
         tidx_ff  <= tidx_in;
      end
   end

   always_ff @(posedge clock) begin
      last_ff     <= last_in;
      run_end_ff  <= run_end_in;
      text_end_ff <= text_end_in;
   end

   assign rsp_valid = valid_ff;
   assign run_end   = run_end_ff;
   assign text_end  = text_end_ff;

   // Items are taken only between result runs.
   assert property (@(posedge clock) disable iff (reset)
      accept |-> (state_ff == S_IDLE))
      else $error("input transfer outside idle state");

   // A buffer flush phase always has bytes left to send.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FLUSH1 || state_ff == S_FLUSH2) |-> (cnt_ff != '0))
      else $error("flush phase with empty count");

   // The tail index stays inside the decoded byte count.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_TAIL) |-> (3'(tidx_ff) < tcnt_ff))
      else $error("tail index past tail count");

   // The end-of-text mark is only ever set on the last byte of a run.
   assert property (@(posedge clock) disable iff (reset)
      (valid_ff && text_end_ff) |-> run_end_ff)
      else $error("text end without run end");

   // A result waiting for its transfer is not replaced.
   assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !rsp_ready) |=> (valid_ff && $stable(run_end_ff) && $stable(text_end_ff)))
      else $error("stalled result changed");

endmodule

`default_nettype wire

// ===== hdl/html_entity_decoder.sv =====
// Top level of the HTML entity decoder: controller and datapath on valid/ready channels.
// A decoded or passed-through byte is offered in the cycle after its input transfer;
// a run that opens with buffered bytes goes through the buffer read register first.
// Throughput: one byte per cycle while each byte yields at most one result and the output is not stalled.
// An item with several results holds off the next input until its last result is loaded;
// a flush sends at most MAX_ENTITY_LEN bytes, one per cycle while the output is ready.
// Synchronous reset returns to idle with no open reference; the buffer itself is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module html_entity_decoder import hed_pkg::*; #(
   parameter int MAX_ENTITY_LEN = HED_MAX_ENTITY_LEN,
   localparam int CNT_W = $clog2(MAX_ENTITY_LEN + 1)
) (
   input wire logic   clock,
   input wire logic   reset,
   hed_req_if.sink    req_ch,
   hed_rsp_if.source  rsp_ch
);

   cmd_type          cmd;
   plan_type         plan;
   logic [CNT_W-1:0] f1_cnt;
   logic [CNT_W-1:0] f2_cnt;

   hed_ctrl #(
      .MAX_ENTITY_LEN(MAX_ENTITY_LEN)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_ready (rsp_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .run_end   (rsp_ch.run_end),
      .text_end  (rsp_ch.text_end),
      .plan      (plan),
      .f1_cnt    (f1_cnt),
      .f2_cnt    (f2_cnt),
      .cmd       (cmd)
   );

   hed_datapath #(
      .MAX_ENTITY_LEN(MAX_ENTITY_LEN)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .text_byte (req_ch.text_byte),
      .is_last   (req_ch.is_last),
      .cmd       (cmd),
      .plan      (plan),
      .f1_cnt    (f1_cnt),
      .f2_cnt    (f2_cnt),
      .out_byte  (rsp_ch.out_byte)
   );

endmodule

`default_nettype wire

// ===== bench/tb_html_entity_decoder.sv =====
// Self-checking testbench for the HTML entity decoder with a predicting scoreboard.
`timescale 1ns / 1ps

module tb_html_entity_decoder;
   import hed_pkg::*;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       is_last;
   } text_item_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_end;
      logic       text_end;
   } decoded_type;

   // Tracks the open reference the same way the decoder does and queues the bytes it owes.
   class entity_scoreboard;
      string      ent_names[6] = '{"amp;", "lt;", "gt;", "quot;", "apos;", "nbsp;"};
      logic [7:0] ent_values[6] = '{CHAR_AMP, CHAR_LT, CHAR_GT, CHAR_QUOT, CHAR_APOS,
                                    CHAR_SPACE};
      logic [7:0]  held[HED_MAX_ENTITY_LEN];
      int          held_count;
      mode_type    mode;
      int unsigned code;
      bit          too_large;
      bit          hex;
      logic [7:0]  step_bytes[$];
      decoded_type expected_q[$];
      int          mismatches;

      function new();
         clear();
         mismatches = 0;
      endfunction

      function void clear();
         held_count = 0;
         mode = MODE_IDLE;
         code = 0;
         too_large = 0;
         hex = 0;
      endfunction

      function void emit(logic [7:0] b);
         step_bytes.push_back(b);
      endfunction

      function void flush_held();
         for (int i = 0; i < held_count; i++) emit(held[i]);
         clear();
      endfunction

      function bit keep(logic [7:0] b);
         if (held_count >= HED_MAX_ENTITY_LEN) return 1'b0;
         held[held_count] = b;
         held_count++;
         return 1'b1;
      endfunction

      function void start_fresh(logic [7:0] b);
         if (b == CHAR_AMP) begin
            clear();
            held[0] = b;
            held_count = 1;
            mode = MODE_NAME;
         end else begin
            emit(b);
         end
      endfunction

      // The buffered bytes go out literally and the breaking byte starts over.
      function void abandon(logic [7:0] b);
         flush_held();
         start_fresh(b);
      endfunction

      function int digit_value(logic [7:0] b);
         if (b >= "0" && b <= "9") return b - "0";
         if (hex && b >= "a" && b <= "f") return b - "a" + 10;
         if (hex && b >= "A" && b <= "F") return b - "A" + 10;
         return -1;
      endfunction

      function void emit_code(int unsigned cp);
         if (cp < 'h80) begin
            emit(8'(cp));
         end else if (cp < 'h800) begin
            emit(8'('hC0 | (cp >> 6)));
            emit(8'('h80 | (cp & 'h3F)));
         end else if (cp < 'h10000) begin
            emit(8'('hE0 | (cp >> 12)));
            emit(8'('h80 | ((cp >> 6) & 'h3F)));
            emit(8'('h80 | (cp & 'h3F)));
         end else begin
            emit(8'('hF0 | (cp >> 18)));
            emit(8'('h80 | ((cp >> 12) & 'h3F)));
            emit(8'('h80 | ((cp >> 6) & 'h3F)));
            emit(8'('h80 | (cp & 'h3F)));
         end
      endfunction

      function void name_byte(logic [7:0] b);
         int k;
         bit partial;
         bit same;
         k = held_count - 1;
         partial = 0;
         if (k == 0 && b == CHAR_HASH) begin
            void'(keep(b));
            mode = MODE_NUM;
            hex = 0;
            code = 0;
            too_large = 0;
            return;
         end
         for (int i = 0; i < 6; i++) begin
            if (k >= ent_names[i].len()) continue;
            same = 1;
            for (int j = 0; j < k; j++) begin
               if (ent_names[i][j] != held[j + 1]) same = 0;
            end
            if (!same || ent_names[i][k] != b) continue;
            if (k + 1 == ent_names[i].len()) begin
               clear();
               emit(ent_values[i]);
               return;
            end
            partial = 1;
         end
         if (partial && keep(b)) return;
         abandon(b);
      endfunction

      function void number_byte(logic [7:0] b);
         int d;
         int unsigned v;
         int unsigned cp;
         if (b == CHAR_SEMI) begin
            cp = code;
            if (!too_large && cp != 0 && cp < CODE_LIMIT &&
                !(cp >= SURROGATE_LOW && cp <= SURROGATE_HIGH)) begin
               clear();
               emit_code(cp);
            end else begin
               flush_held();
               emit(b);
            end
            return;
         end
         if (held_count == 2 && !hex && (b == CHAR_X_LO || b == CHAR_X_UP)) begin
            void'(keep(b));
            hex = 1;
            return;
         end
         d = digit_value(b);
         if (d < 0 || !keep(b)) begin
            abandon(b);
            return;
         end
         // Past the largest code point the value freezes and only the flag remembers it.
         if (!too_large) begin
            v = code * (hex ? 16 : 10) + d;
            if (v > 'h10FFFF) too_large = 1;
            else code = v;
         end
      endfunction

      function void note_input(logic [7:0] b, logic last);
         decoded_type d;
         step_bytes.delete();
         if (held_count == 0 || mode == MODE_IDLE) begin
            clear();
            start_fresh(b);
         end else if (mode == MODE_NAME) begin
            name_byte(b);
         end else begin
            number_byte(b);
         end
         if (last) flush_held();
         foreach (step_bytes[i]) begin
            d.out_byte = step_bytes[i];
            d.run_end = (i == step_bytes.size() - 1);
            d.text_end = last && (i == step_bytes.size() - 1);
            expected_q.push_back(d);
         end
      endfunction

      task report(string msg);
         $display("MISMATCH at %0t: %s", $realtime, msg);
         mismatches++;
      endtask

      task check_result(logic [7:0] out_byte, logic run_end, logic text_end);
         decoded_type want;
         if (expected_q.size() == 0) begin
            report($sformatf("unexpected byte 0x%02h", out_byte));
            return;
         end
         want = expected_q.pop_front();
         if (out_byte !== want.out_byte)
            report($sformatf("out_byte 0x%02h, expected 0x%02h", out_byte, want.out_byte));
         if (run_end !== want.run_end)
            report($sformatf("run_end %b, expected %b on byte 0x%02h", run_end, want.run_end,
                             want.out_byte));
         if (text_end !== want.text_end)
            report($sformatf("text_end %b, expected %b on byte 0x%02h", text_end,
                             want.text_end, want.out_byte));
      endtask
   endclass

   logic clock;
   logic reset;

   hed_req_if req_ch ();
   hed_rsp_if rsp_ch ();

   html_entity_decoder dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   entity_scoreboard sb = new();
   text_item_type    text_q[$];
   bit               random_ends;
   bit               req_eager;
   bit               rsp_eager;
   bit               hold_request;

   initial clock = 1'b0;
   always #1 clock = ~clock;

   initial begin
      #1_000_000;
      $display("Test completed with failures");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready)
            sb.note_input(req_ch.text_byte, req_ch.is_last);
         if (rsp_ch.valid && rsp_ch.ready)
            sb.check_result(rsp_ch.out_byte, rsp_ch.run_end, rsp_ch.text_end);
      end
   end

   function void add_byte(logic [7:0] b);
      text_q.push_back({b, random_ends && ($urandom_range(0, 29) == 0)});
   endfunction

   function void add_text(string s);
      for (int i = 0; i < s.len(); i++) add_byte(s[i]);
   endfunction

   task automatic send_item(input text_item_type item);
      int gap;
      gap = req_eager ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         @(negedge clock);
         req_ch.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_ch.valid <= 1'b1;
      req_ch.text_byte <= item.text_byte;
      req_ch.is_last <= item.is_last;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // Output side: random back-pressure, plus one long hold-off on request.
   initial begin
      int gap;
      rsp_ch.ready = 1'b0;
      wait (reset === 1'b0);
      forever begin
         if (hold_request) begin
            @(negedge clock);
            rsp_ch.ready <= 1'b0;
            repeat (200) @(negedge clock);
            hold_request = 0;
         end
         gap = rsp_eager ? 0 : $urandom_range(0, 7);
         if (gap > 0) begin
            @(negedge clock);
            rsp_ch.ready <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
         @(negedge clock);
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
      end
   end

   initial begin
      string       s;
      string       breakers;
      string       digits;
      int unsigned cp;
      int          directed_n;
      int          pos;
      bit          hex_ref;
      int unsigned edges[11];

      breakers = " -+xXg&;#q";
      digits = "0123456789abcdefABCDEF";
      edges = '{1, 'h7F, 'h80, 'h7FF, 'h800, 'hD7FF, 'hE000, 'hFFFF, 'h10000, 'h10FFFF,
                'h110000};
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.text_byte = 8'h00;
      req_ch.is_last = 1'b0;
      req_eager = 0;
      rsp_eager = 0;
      hold_request = 0;

      // Directed text: a name, a four-byte code point, a surrogate, the byte extremes.
      random_ends = 0;
      add_text("&gt;&#x1F600;&#55296;");
      add_byte(8'hFF);
      add_byte(8'h01);
      text_q[text_q.size() - 1].is_last = 1'b1;
      directed_n = text_q.size();

      random_ends = 1;
      while (text_q.size() < 210) begin
         case ($urandom_range(0, 9))
            0, 1: begin
               repeat ($urandom_range(1, 6)) begin
                  if ($urandom_range(0, 3) == 0) add_byte(8'($urandom_range(1, 255)));
                  else add_byte(8'($urandom_range(8'h20, 8'h7E)));
               end
            end
            2, 3: begin
               s = {"&", sb.ent_names[$urandom_range(0, 5)]};
               if ($urandom_range(0, 3) == 0) begin
                  pos = $urandom_range(1, s.len() - 1);
                  s = s.substr(0, pos);
                  s[pos] = breakers[$urandom_range(0, breakers.len() - 1)];
               end
               add_text(s);
            end
            4, 5, 6: begin
               case ($urandom_range(0, 7))
                  0: cp = $urandom_range(1, 'h7F);
                  1: cp = $urandom_range('h80, 'h7FF);
                  2: cp = $urandom_range('h800, 'hFFFF);
                  3: cp = $urandom_range('h10000, 'h10FFFF);
                  4: cp = $urandom_range('hD800, 'hDFFF);
                  5: cp = $urandom_range('h110000, 'h3FFFFFF);
                  6: cp = 0;
                  default: cp = edges[$urandom_range(0, 10)];
               endcase
               hex_ref = $urandom_range(0, 1);
               if (hex_ref) begin
                  s = $sformatf("%0h", cp);
                  for (int i = 0; i < s.len(); i++) begin
                     if (s[i] >= "a" && $urandom_range(0, 1)) s[i] = s[i] - 8'h20;
                  end
               end else begin
                  s = $sformatf("%0d", cp);
               end
               if ($urandom_range(0, 3) == 0) begin
                  repeat ($urandom_range(1, 10)) s = {"0", s};
               end
               if (!hex_ref) s = {"&#", s, ";"};
               else if ($urandom_range(0, 1)) s = {"&#x", s, ";"};
               else s = {"&#X", s, ";"};
               if ($urandom_range(0, 4) == 0) begin
                  pos = $urandom_range(2, s.len() - 1);
                  if ($urandom_range(0, 2) == 0) s[pos] = 8'($urandom_range(1, 255));
                  else s[pos] = breakers[$urandom_range(0, breakers.len() - 1)];
               end
               add_text(s);
            end
            7: begin
               // Long references, some of which run past the buffer.
               hex_ref = $urandom_range(0, 1);
               s = hex_ref ? "&#x" : "&#";
               repeat ($urandom_range(12, 16)) begin
                  s = {s, "0"};
                  s[s.len() - 1] = digits[$urandom_range(0, hex_ref ? 21 : 9)];
               end
               add_text(s);
               if ($urandom_range(0, 2) == 0) add_byte(8'($urandom_range(1, 255)));
               else add_byte(CHAR_SEMI);
            end
            8: begin
               case ($urandom_range(0, 3))
                  0: add_text("&#;");
                  1: add_text("&#x;");
                  2: add_text("&#X;");
                  default: add_text("&#39;");
               endcase
            end
            default: begin
               add_byte(CHAR_AMP);
               repeat ($urandom_range(1, 3)) add_byte(8'($urandom_range(1, 255)));
            end
         endcase
      end
      text_q[text_q.size() - 1].is_last = 1'b1;

      repeat (2) @(negedge clock);
      reset <= 1'b0;

      foreach (text_q[i]) begin
         if (i % 40 == 0) begin
            req_eager = ($urandom_range(0, 2) == 0);
            rsp_eager = ($urandom_range(0, 2) == 0);
         end
         if (i == directed_n + 20) hold_request = 1;
         send_item(text_q[i]);
      end
      @(negedge clock);
      req_ch.valid <= 1'b0;

      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
